// ===== hdl/cld_pkg.sv =====
package cld_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned MAX_LEN_W = 25;
	localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 25'd16777216;

	localparam int unsigned KEYWORD_LEN = 15;
	localparam int unsigned KW_IDX_W = 4;

	localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
	localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
	localparam logic [BYTE_W-1:0] CHAR_TAB = 8'h09;
	localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CHAR_PLUS = 8'h2B;
	localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_BODY       = 2'd0,
		STATUS_NO_LENGTH  = 2'd1,
		STATUS_BAD_LENGTH = 2'd2
	} status_t;

	// where the value parse stands within the header
	typedef enum logic [1:0] {
		PH_SEARCH = 2'd0,
		PH_BLANK  = 2'd1,
		PH_VALUE  = 2'd2,
		PH_DONE   = 2'd3
	} num_phase_t;

	// bytes of "Content-Length:"
	function automatic logic [BYTE_W-1:0] keyword_char(input logic [KW_IDX_W-1:0] idx);
		logic [BYTE_W-1:0] c;
		unique case (idx)
			4'd0:    c = 8'h43;
			4'd1:    c = 8'h6F;
			4'd2:    c = 8'h6E;
			4'd3:    c = 8'h74;
			4'd4:    c = 8'h65;
			4'd5:    c = 8'h6E;
			4'd6:    c = 8'h74;
			4'd7:    c = 8'h2D;
			4'd8:    c = 8'h4C;
			4'd9:    c = 8'h65;
			4'd10:   c = 8'h6E;
			4'd11:   c = 8'h67;
			4'd12:   c = 8'h74;
			4'd13:   c = 8'h68;
			4'd14:   c = 8'h3A;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/cld_byte_if.sv =====
interface cld_byte_if;
	logic                        valid;
	logic                        ready;
	logic [cld_pkg::BYTE_W-1:0]  data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

// ===== hdl/cld_result_if.sv =====
interface cld_result_if;
	logic                         valid;
	logic                         ready;
	logic [cld_pkg::BYTE_W-1:0]   body_byte;
	logic                         last;
	logic [cld_pkg::STATUS_W-1:0] status;

	modport source (output valid, output body_byte, output last, output status, input ready);
	modport sink (input valid, input body_byte, input last, input status, output ready);
endinterface

// ===== hdl/cld_cfg_if.sv =====
interface cld_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [cld_pkg::MAX_LEN_W-1:0]  max_body_length;

	modport source (output valid, output max_body_length, input ready);
	modport sink (input valid, input max_body_length, output ready);
endinterface

// ===== hdl/content_length_deframer_top.sv =====
// content-length deframer: takes one raw byte per cycle, scans each header up to
// cr lf cr lf, picks up the first "Content-Length:" value (atoi style: blanks,
// optional sign, digits, cut at header end) and then passes exactly that many body
// bytes, flagging the final one with last. a header without a length gives one
// status transaction of 1, a header whose length is zero, negative, overflowed or
// above max_body_length gives status 2; header bytes otherwise give no output.
// a byte is taken every cycle (sustained rate one byte per clock) as long as the
// result register drains; the path is an input register, combinational matcher and
// parser logic, and the result register, so a result is registered from the byte
// held in the input register once that byte advances. the single stall source is a
// full result register holding a transaction that the sink has not taken while the
// held byte would make a result.
// max_body_length must be written through cfg only while the block is idle; the block does not enforce this.
module content_length_deframer_top #(
	parameter int unsigned LENGTH_BITS = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	cld_cfg_if.sink      cfg,
	cld_byte_if.sink     data,
	cld_result_if.source msg
);
	import cld_pkg::*;

	localparam int unsigned LV_W = LENGTH_BITS + 1;
	localparam int unsigned PROD_W = LV_W + 4;
	localparam int unsigned CMP_W = (LV_W > MAX_LEN_W) ? LV_W : MAX_LEN_W;
	localparam logic [PROD_W-1:0] LIMIT = PROD_W'(1) << LENGTH_BITS;

	// configuration register
	logic [MAX_LEN_W-1:0] max_len_q;

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;

	// deframer state
	logic                   in_body_q;
	logic [1:0]             sep_q;
	logic [KW_IDX_W-1:0]    kw_q;
	num_phase_t             phase_q;
	logic                   neg_q;
	logic [LV_W-1:0]        len_q;
	logic                   ovf_q;
	logic [LENGTH_BITS-1:0] remain_q;

	// result register
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;
	status_t           out_status_q;

	// next state
	logic                   in_body_n;
	logic [1:0]             sep_n;
	logic [KW_IDX_W-1:0]    kw_n;
	num_phase_t             phase_n;
	logic                   neg_n;
	logic [LV_W-1:0]        len_n;
	logic                   ovf_n;
	logic [LENGTH_BITS-1:0] remain_n;

	logic              produce;
	logic [BYTE_W-1:0] res_byte;
	logic              res_last;
	status_t           res_status;

	logic              is_blank;
	logic              is_digit;
	logic [PROD_W-1:0] prod;
	logic              hdr_end;
	logic              bad_len;
	logic              advance;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg.valid) begin
			max_len_q <= cfg.max_body_length;
		end
	end

	// byte classes
	assign is_blank = (data_s1 == CHAR_SPACE) || ((data_s1 >= CHAR_TAB) && (data_s1 <= CHAR_CR));
	assign is_digit = (data_s1 >= CHAR_ZERO) && (data_s1 <= CHAR_NINE);

	// len * 10 + digit, by shifts
	assign prod = (PROD_W'(len_q) << 3) + (PROD_W'(len_q) << 1)
		+ PROD_W'(data_s1 - CHAR_ZERO);

	always_comb begin
		in_body_n  = in_body_q;
		sep_n      = sep_q;
		kw_n       = kw_q;
		phase_n    = phase_q;
		neg_n      = neg_q;
		len_n      = len_q;
		ovf_n      = ovf_q;
		remain_n   = remain_q;
		produce    = 1'b0;
		res_byte   = data_s1;
		res_last   = 1'b0;
		res_status = STATUS_BODY;
		hdr_end    = 1'b0;
		bad_len    = 1'b0;

		if (in_body_q) begin
			// body: pass every byte, count down to the last one
			produce  = 1'b1;
			res_last = (remain_q == '0);
			if (remain_q == '0) begin
				in_body_n = 1'b0;
			end else begin
				remain_n = remain_q - LENGTH_BITS'(1);
			end
		end else begin
			// keyword match and value parse
			unique case (phase_q)
				PH_SEARCH: begin
					if ((kw_q < KW_IDX_W'(KEYWORD_LEN)) && (data_s1 == keyword_char(kw_q))) begin
						kw_n = kw_q + KW_IDX_W'(1);
					end else begin
						kw_n = (data_s1 == keyword_char('0)) ? KW_IDX_W'(1) : '0;
					end
					if (kw_n >= KW_IDX_W'(KEYWORD_LEN)) begin
						phase_n = PH_BLANK;
					end
				end
				PH_BLANK: begin
					priority if (is_blank) begin
						phase_n = PH_BLANK;
					end else if (data_s1 == CHAR_PLUS) begin
						phase_n = PH_VALUE;
					end else if (data_s1 == CHAR_MINUS) begin
						neg_n   = 1'b1;
						phase_n = PH_VALUE;
					end else if (is_digit) begin
						phase_n = PH_VALUE;
					end else begin
						phase_n = PH_DONE;
					end
				end
				PH_VALUE: begin
					if (!is_digit) begin
						phase_n = PH_DONE;
					end
				end
				PH_DONE: begin
					phase_n = PH_DONE;
				end
			endcase

			// digit accumulate, saturating at 2^LENGTH_BITS
			if (is_digit && ((phase_q == PH_BLANK) || (phase_q == PH_VALUE))) begin
				if (prod > LIMIT) begin
					len_n = LIMIT[LV_W-1:0];
					ovf_n = 1'b1;
				end else begin
					len_n = prod[LV_W-1:0];
				end
			end

			// separator cr lf cr lf
			priority if (data_s1 == CHAR_CR) begin
				sep_n = (sep_q == 2'd2) ? 2'd3 : 2'd1;
			end else if (data_s1 == CHAR_LF) begin
				priority if (sep_q == 2'd1) begin
					sep_n = 2'd2;
				end else if (sep_q == 2'd3) begin
					hdr_end = 1'b1;
				end else begin
					sep_n = 2'd0;
				end
			end else begin
				sep_n = 2'd0;
			end

			bad_len = neg_n || ovf_n || (len_n == '0)
				|| (CMP_W'(len_n) > CMP_W'(max_len_q));

			if (hdr_end) begin
				// header done: report, or switch to body
				res_byte = '0;
				priority if (phase_n == PH_SEARCH) begin
					produce    = 1'b1;
					res_status = STATUS_NO_LENGTH;
				end else if (bad_len) begin
					produce    = 1'b1;
					res_status = STATUS_BAD_LENGTH;
				end else begin
					in_body_n = 1'b1;
					remain_n  = LENGTH_BITS'(len_n - LV_W'(1));
				end
				sep_n   = 2'd0;
				kw_n    = '0;
				phase_n = PH_SEARCH;
				neg_n   = 1'b0;
				len_n   = '0;
				ovf_n   = 1'b0;
			end
		end
	end

	// the held byte moves on unless it makes a result the full output register can't take
	assign advance = valid_s1 && (!produce || !out_valid_q || msg.ready);
	assign data.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data.ready) begin
			valid_s1 <= data.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data.ready && data.valid) begin
			data_s1 <= data.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_body_q <= 1'b0;
			sep_q     <= 2'd0;
			kw_q      <= '0;
			phase_q   <= PH_SEARCH;
			neg_q     <= 1'b0;
			len_q     <= '0;
			ovf_q     <= 1'b0;
			remain_q  <= '0;
		end else if (advance) begin
			in_body_q <= in_body_n;
			sep_q     <= sep_n;
			kw_q      <= kw_n;
			phase_q   <= phase_n;
			neg_q     <= neg_n;
			len_q     <= len_n;
			ovf_q     <= ovf_n;
			remain_q  <= remain_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && produce) begin
			out_valid_q <= 1'b1;
		end else if (msg.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			out_byte_q   <= res_byte;
			out_last_q   <= res_last;
			out_status_q <= res_status;
		end
	end

	assign msg.valid     = out_valid_q;
	assign msg.body_byte = out_byte_q;
	assign msg.last      = out_last_q;
	assign msg.status    = out_status_q;

endmodule
